/* rtl/assert_macros.svh */
// Assertion shorthands for the checker. Each expects signals named clk and rst
// in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pto_pkg.sv */
package pto_pkg;

  localparam int DATA_W    = 32;
  localparam int REG_W     = 31;
  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 2;
  localparam int T1_W      = 48;
  localparam int T2_W      = 49;
  localparam int K_W       = 34;
  localparam int NUM_W     = 35;
  localparam int MAG_W     = 34;
  localparam int NUM_CELLS = 32;
  localparam int STEP_W    = 6;
  localparam int DVD_W     = 64;

  localparam logic [MODE_W-1:0] MODE_SOFT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCAD = 2'd2;

  localparam logic [ADDR_W-1:0] REG_MODE       = 2'd0;
  localparam logic [ADDR_W-1:0] REG_LAMBDA_ONE = 2'd1;
  localparam logic [ADDR_W-1:0] REG_LAMBDA_TWO = 2'd2;
  localparam logic [ADDR_W-1:0] REG_CONCAVITY  = 2'd3;

  localparam logic [DATA_W-1:0] FX_ONE  = 32'h0001_0000;
  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  localparam logic [REG_W-1:0] ONE_REG         = 31'h0001_0000;
  localparam logic [REG_W-1:0] CONCAVITY_RESET = 31'd196608;
  localparam logic [K_W-1:0]   K_MAX           = 34'h2_0000_0000;
  localparam logic [DVD_W-1:0] TWO_POW_32      = 64'h0000_0001_0000_0000;

  typedef enum logic [2:0] {
    SU_GL1,
    SU_T1,
    SU_T2,
    SU_DIV_G,
    SU_DIV_GM1,
    SU_DIV_K,
    SU_FIN,
    SU_READY
  } pto_setup_state_t;

  // Values derived from the configuration registers.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [REG_W-1:0]  l1;
    logic [DATA_W-1:0] opl2;
    logic [T1_W-1:0]   t1;
    logic [T2_W-1:0]   t2;
    logic [K_W-1:0]    k;
    logic [DATA_W-1:0] d1;
    logic [DATA_W-1:0] d2;
    logic              flt1;
    logic              flt2;
  } pto_cfg_t;

  // What one divider cell hands to the next.
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] dvd;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] den;
    logic              neg;
    logic              ovf;
    logic              fault;
  } pto_cell_t;

endpackage

/* rtl/penalty_threshold_operator_top.sv */
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata = value_in
// m_*      out  m_tvalid/m_tready  m_tdata = value_out, m_tuser = divide_fault
// cfg_*    in   cfg_we             cfg_addr = register index, cfg_data = value
//
// Sustains one request per cycle unless the m side stalls; the path holds three
// front stages, 32 divider cells that each settle one quotient bit, and the
// output register. After reset and every configuration write a setup sequencer
// works out the breakpoints and divisors in three shared multiplier steps,
// three 64-step divisions and one finish step; s_tready stays low meanwhile.
// Reset is synchronous; it clears the valid bits and sets the configuration registers to their defaults.
// A stall on the m side backs up cell by cell; empty cells keep taking work.
module penalty_threshold_operator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_addr,
  input  logic [30:0]               cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic signed [31:0]        s_tdata,   // [31:0] value_in
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic signed [31:0]        m_tdata,   // [31:0] value_out
  output logic                      m_tuser    // [0] divide_fault
);
  import pto_pkg::*;

  pto_cfg_t          cfg;
  logic              setup_ready;
  logic              front_ready;
  logic              take;

  logic              link_valid [NUM_CELLS+1];
  logic              link_ready [NUM_CELLS+1];
  pto_cell_t         link_data  [NUM_CELLS+1];

  pto_cell_t         fin;
  logic              o_ready;
  logic              ov;
  logic [DATA_W-1:0] o_value;
  logic              o_fault;
  logic [DATA_W-1:0] value_sel;

  pto_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg_ready (setup_ready),
    .cfg_out   (cfg)
  );

  assign take     = setup_ready & ~cfg_we;
  assign s_tready = front_ready & take;

  pto_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid & take),
    .in_ready  (front_ready),
    .in_value  (s_tdata),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_data  (link_data[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    pto_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_data   (link_data[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_data  (link_data[i+1])
    );
  end

  assign fin                   = link_data[NUM_CELLS];
  assign o_ready               = ~ov | m_tready;
  assign link_ready[NUM_CELLS] = o_ready;

  // Force a faulted result to zero; otherwise apply the sign and saturate to the signed 32-bit range.
  always_comb begin
    if (fin.fault) begin
      value_sel = '0;
    end else if (fin.ovf || fin.quo[DATA_W-1]) begin
      value_sel = fin.neg ? SAT_NEG : SAT_POS;
    end else begin
      value_sel = fin.neg ? (~fin.quo + 32'd1) : fin.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (o_ready) begin
      ov <= link_valid[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && link_valid[NUM_CELLS]) begin
      o_value <= value_sel;
      o_fault <= fin.fault;
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = o_value;
  assign m_tuser  = o_fault;

endmodule

/* rtl/pto_setup.sv */
module pto_setup (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pto_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [pto_pkg::REG_W-1:0]   cfg_data,
  output logic                        cfg_ready,
  output pto_pkg::pto_cfg_t           cfg_out
);
  import pto_pkg::*;

  pto_setup_state_t state;
  pto_setup_state_t state_next;

  logic [MODE_W-1:0] mode;
  logic [REG_W-1:0]  l1;
  logic [REG_W-1:0]  l2;
  logic [REG_W-1:0]  gam;

  logic [DATA_W-1:0] opl2;
  logic [REG_W-1:0]  gm1_den;
  logic              gm1_pos;

  logic [61:0]       gl1;
  logic [T1_W-1:0]   t1;
  logic [T2_W-1:0]   t2;
  logic [32:0]       inv_g;
  logic [32:0]       inv_gm1;
  logic [K_W-1:0]    k;
  logic [DATA_W-1:0] d1;
  logic [DATA_W-1:0] d2;
  logic              flt1;
  logic              flt2;

  logic [32:0]       mul_a;
  logic [31:0]       mul_b;
  logic [64:0]       prod;
  logic [32:0]       t_clamp;

  logic [DVD_W-1:0]  dvd;
  logic [DATA_W-1:0] den;
  logic [DATA_W-1:0] rem;
  logic [DVD_W-1:0]  quo;
  logic [STEP_W-1:0] cnt;
  logic              div_last;
  logic [32:0]       rsh;
  logic [33:0]       dif;
  logic              qbit;
  logic [DATA_W-1:0] rem_step;
  logic [DVD_W-1:0]  quo_step;

  logic [33:0]       d1_full;
  logic [33:0]       d2_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SOFT;
      l1   <= '0;
      l2   <= '0;
      gam  <= CONCAVITY_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:       mode <= cfg_data[MODE_W-1:0];
        REG_LAMBDA_ONE: l1   <= cfg_data;
        REG_LAMBDA_TWO: l2   <= cfg_data;
        REG_CONCAVITY:  gam  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign opl2    = {1'b0, l2} + FX_ONE;
  assign gm1_pos = gam > ONE_REG;
  assign gm1_den = gam - ONE_REG;

  // One shared multiplier serves the three breakpoint products in turn.
  assign t_clamp = (|gl1[61:48]) ? 33'h1_0000_0000 : {1'b0, gl1[47:16]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      SU_GL1: begin
        mul_a = {2'b0, gam};
        mul_b = {1'b0, l1};
      end
      SU_T1: begin
        mul_a = {2'b0, l1};
        mul_b = opl2;
      end
      SU_T2: begin
        mul_a = t_clamp;
        mul_b = opl2;
      end
      default: ;
    endcase
  end

  assign prod = {32'b0, mul_a} * {33'b0, mul_b};

  // Restoring divider, one quotient bit per cycle over a 64-bit dividend.
  assign div_last = (cnt == {STEP_W{1'b1}});
  assign rsh      = {rem, dvd[DVD_W-1]};
  assign dif      = {1'b0, rsh} - {2'b0, den};
  assign qbit     = ~dif[33];
  assign rem_step = qbit ? dif[31:0] : rsh[31:0];
  assign quo_step = {quo[DVD_W-2:0], qbit};

  assign d1_full = {2'b0, opl2} - {1'b0, inv_g};
  assign d2_full = {2'b0, opl2} - {1'b0, inv_gm1};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SU_GL1;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cfg_ready  = 1'b0;
    case (state)
      SU_GL1:     state_next = SU_T1;
      SU_T1:      state_next = SU_T2;
      SU_T2:      state_next = SU_DIV_G;
      SU_DIV_G:   if (div_last) state_next = SU_DIV_GM1;
      SU_DIV_GM1: if (div_last) state_next = SU_DIV_K;
      SU_DIV_K:   if (div_last) state_next = SU_FIN;
      SU_FIN:     state_next = SU_READY;
      SU_READY:   cfg_ready = 1'b1;
      default:    state_next = SU_GL1;
    endcase
    if (cfg_we) state_next = SU_GL1;
  end

  always_ff @(posedge clk) begin
    case (state)
      SU_GL1: gl1 <= prod[61:0];
      SU_T1:  t1 <= {1'b0, prod[62:16]} + {17'b0, l1};
      SU_T2: begin
        t2  <= prod[64:16];
        dvd <= TWO_POW_32;
        den <= {1'b0, gam};
        rem <= '0;
        quo <= '0;
        cnt <= '0;
      end
      SU_DIV_G: begin
        if (div_last) begin
          inv_g <= quo_step[32:0];
          dvd   <= TWO_POW_32;
          den   <= {1'b0, gm1_den};
          rem   <= '0;
          quo   <= '0;
          cnt   <= '0;
        end else begin
          dvd <= {dvd[DVD_W-2:0], 1'b0};
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt + 1'b1;
        end
      end
      SU_DIV_GM1: begin
        if (div_last) begin
          inv_gm1 <= quo_step[32:0];
          dvd     <= {2'b0, gl1};
          den     <= {1'b0, gm1_den};
          rem     <= '0;
          quo     <= '0;
          cnt     <= '0;
        end else begin
          dvd <= {dvd[DVD_W-2:0], 1'b0};
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt + 1'b1;
        end
      end
      SU_DIV_K: begin
        if (div_last) begin
          k <= (quo_step > {30'b0, K_MAX}) ? K_MAX : quo_step[K_W-1:0];
        end else begin
          dvd <= {dvd[DVD_W-2:0], 1'b0};
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt + 1'b1;
        end
      end
      SU_FIN: begin
        // A divisor of zero or below faults the branch that would use it.
        d1   <= d1_full[31:0];
        d2   <= d2_full[31:0];
        flt1 <= (gam == '0) | d1_full[33] | (d1_full == '0);
        flt2 <= ~gm1_pos | d2_full[33] | (d2_full == '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    cfg_out.mode = mode;
    cfg_out.l1   = l1;
    cfg_out.opl2 = opl2;
    cfg_out.t1   = t1;
    cfg_out.t2   = t2;
    cfg_out.k    = k;
    cfg_out.d1   = d1;
    cfg_out.d2   = d2;
    cfg_out.flt1 = flt1;
    cfg_out.flt2 = flt2;
  end

endmodule

/* rtl/pto_front.sv */
module pto_front (
  input  logic                       clk,
  input  logic                       rst,
  input  pto_pkg::pto_cfg_t          cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [pto_pkg::DATA_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pto_pkg::pto_cell_t         out_data
);
  import pto_pkg::*;

  logic              va;
  logic              vb;
  logic              vc;
  logic              rdy_a;
  logic              rdy_b;
  logic              rdy_c;

  logic [DATA_W-1:0] z_u;
  logic [DATA_W-1:0] mag_in;
  logic [DATA_W-1:0] a_m;
  logic              a_neg;

  logic              gt_l1;
  logic              le_t1;
  logic              le_t2;
  logic [NUM_W-1:0]  m_ext;
  logic [NUM_W-1:0]  diff_l1;
  logic [NUM_W-1:0]  diff_k;
  logic [NUM_W-1:0]  num_sel;
  logic [DATA_W-1:0] den_sel;
  logic              flt_sel;

  logic [NUM_W-1:0]  b_num;
  logic [DATA_W-1:0] b_den;
  logic              b_fault;
  logic              b_neg;

  logic [NUM_W-1:0]  num_neg;
  logic [MAG_W-1:0]  absn;
  pto_cell_t         init;

  assign rdy_c    = ~vc | out_ready;
  assign rdy_b    = ~vb | rdy_c;
  assign rdy_a    = ~va | rdy_b;
  assign in_ready = rdy_a;

  // Stage A: magnitude and sign of the estimate.
  assign z_u    = in_value;
  assign mag_in = z_u[DATA_W-1] ? (~z_u + 32'd1) : z_u;

  // Stage B: pick the branch, its numerator and its divisor. Paths with no
  // division run through the cells with a divisor of one.
  assign gt_l1   = a_m > {1'b0, cfg.l1};
  assign le_t1   = {16'b0, a_m} <= cfg.t1;
  assign le_t2   = {17'b0, a_m} <= cfg.t2;
  assign m_ext   = {3'b0, a_m};
  assign diff_l1 = {3'b0, a_m} - {4'b0, cfg.l1};
  assign diff_k  = {3'b0, a_m} - {1'b0, cfg.k};

  always_comb begin
    num_sel = '0;
    den_sel = FX_ONE;
    flt_sel = 1'b0;
    case (cfg.mode)
      MODE_SOFT: if (gt_l1) num_sel = diff_l1;
      MODE_FIRM: begin
        if (gt_l1) begin
          if (le_t2) begin
            if (cfg.flt1) begin
              flt_sel = 1'b1;
            end else begin
              num_sel = diff_l1;
              den_sel = cfg.d1;
            end
          end else begin
            num_sel = m_ext;
            den_sel = cfg.opl2;
          end
        end
      end
      MODE_SCAD: begin
        if (gt_l1) begin
          if (le_t1) begin
            num_sel = diff_l1;
            den_sel = cfg.opl2;
          end else if (le_t2) begin
            if (cfg.flt2) begin
              flt_sel = 1'b1;
            end else begin
              num_sel = diff_k;
              den_sel = cfg.d2;
            end
          end else begin
            num_sel = m_ext;
            den_sel = cfg.opl2;
          end
        end
      end
      default: ;
    endcase
  end

  // Stage C: split the numerator into sign and magnitude, catch quotients
  // of 2^32 or more, and seed the first cell.
  assign num_neg = -b_num;
  assign absn    = b_num[NUM_W-1] ? num_neg[MAG_W-1:0] : b_num[MAG_W-1:0];

  always_comb begin
    init.rem   = {14'b0, absn[MAG_W-1:16]};
    init.dvd   = {absn[15:0], 16'b0};
    init.quo   = '0;
    init.den   = b_den;
    init.neg   = b_neg ^ b_num[NUM_W-1];
    init.ovf   = {14'b0, absn} >= {b_den, 16'b0};
    init.fault = b_fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_m   <= mag_in;
      a_neg <= z_u[DATA_W-1];
    end
    if (rdy_b && va) begin
      b_num   <= num_sel;
      b_den   <= den_sel;
      b_fault <= flt_sel;
      b_neg   <= a_neg;
    end
    if (rdy_c && vb) begin
      out_data <= init;
    end
  end

  assign out_valid = vc;

endmodule

/* rtl/pto_div_cell.sv */
module pto_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pto_pkg::pto_cell_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pto_pkg::pto_cell_t out_data
);
  import pto_pkg::*;

  logic        vld;
  logic [32:0] rsh;
  logic [33:0] dif;
  logic        qbit;
  pto_cell_t   nxt;

  assign in_ready = ~vld | out_ready;

  // One restoring step: bring down the next dividend bit and subtract the
  // divisor when it fits.
  assign rsh  = {in_data.rem, in_data.dvd[DATA_W-1]};
  assign dif  = {1'b0, rsh} - {2'b0, in_data.den};
  assign qbit = ~dif[33];

  always_comb begin
    nxt     = in_data;
    nxt.rem = qbit ? dif[DATA_W-1:0] : rsh[DATA_W-1:0];
    nxt.dvd = {in_data.dvd[DATA_W-2:0], 1'b0};
    nxt.quo = {in_data.quo[DATA_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

  assign out_valid = vld;

endmodule

/* rtl/pto_checker.sv */
`include "assert_macros.svh"

module pto_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // A faulted result is always forced to zero.
  `ASSERT_IMPLIES(a_fault_zero, m_tvalid && m_tuser, m_tdata == 32'h0, "fault with nonzero value")

  // Setup runs right after reset, so nothing is offered or taken then.
  `ASSERT_IMPLIES(a_reset_quiet, $past(rst), !m_tvalid && !s_tready, "active right after reset")

  // A register write restarts setup, which holds off new requests.
  `ASSERT_NEXT(a_cfg_blocks, cfg_we, !s_tready, "request taken during setup")

  // No request is taken in the same cycle as a register write.
  `ASSERT_IMPLIES(a_take_no_write, s_tvalid && s_tready, !cfg_we, "request taken on write")

  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind penalty_threshold_operator_top pto_checker u_pto_checker (
  .clk      (clk),
  .rst      (rst),
  .cfg_we   (cfg_we),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
